/* sv/euab_pkg.sv */
package euab_pkg;

	// Weight ramp limits on the 3x3 min-max range
	localparam logic [7:0] RampLow  = 8'd24;
	localparam logic [7:0] RampHigh = 8'd96;
	localparam logic [7:0] FullWeight = 8'd255;
	// floor(x * 255 / 72) == (x * RampRecip) >> RampShift for x below 72
	localparam logic [21:0] RampRecip = 22'd3713820;
	localparam int unsigned RampShift = 20;
	// Smoothstep factor 768 - 2 * w
	localparam logic [9:0] SmoothK = 10'd768;

	// One blend job handed from the front to the back
	typedef struct packed {
		logic             last;
		logic [3:0][7:0]  sharp;
		logic [3:0][7:0]  smooth;
		logic [7:0]       span;
	} job_t;

endpackage

/* sv/euab_queue.sv */
module euab_queue import euab_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic push_ready,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	job_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != FullCnt);
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/euab_front.sv */
module euab_front import euab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic        s_tlast,
	output logic        push,
	output job_t        push_job,
	input  logic        push_ready
);

	function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

	logic [2:0][7:0] left_q;
	logic [2:0][7:0] center_q;
	logic [3:0][7:0] smooth_q;
	logic [3:0][7:0] sharp_q;
	logic            held_q;
	logic            second_q;
	job_t            second_job_q;

	logic [2:0][7:0] new_col;
	logic [3:0][7:0] new_smooth;
	logic [3:0][7:0] new_sharp;
	logic [7:0]      l_mn, l_mx, c_mn, c_mx, n_mn, n_mx;
	job_t            job_a;
	job_t            job_b;
	logic            accept;

	assign new_col    = s_tdata[23:0];
	assign new_smooth = s_tdata[55:24];
	assign new_sharp  = s_tdata[87:56];
	assign s_tready   = push_ready && !second_q;
	assign accept     = s_tvalid && s_tready;

	// Classify: column ranges and the jobs this transaction causes
	always_comb begin
		l_mn = min2(min2(left_q[0], left_q[1]), left_q[2]);
		l_mx = max2(max2(left_q[0], left_q[1]), left_q[2]);
		c_mn = min2(min2(center_q[0], center_q[1]), center_q[2]);
		c_mx = max2(max2(center_q[0], center_q[1]), center_q[2]);
		n_mn = min2(min2(new_col[0], new_col[1]), new_col[2]);
		n_mx = max2(max2(new_col[0], new_col[1]), new_col[2]);

		// held column, new column on its right
		job_a.span   = max2(max2(l_mx, c_mx), n_mx) - min2(min2(l_mn, c_mn), n_mn);
		job_a.smooth = smooth_q;
		job_a.sharp  = sharp_q;
		job_a.last   = !s_tlast;

		// flushed new column, right edge replicated
		job_b.span   = held_q ? (max2(c_mx, n_mx) - min2(c_mn, n_mn)) : (n_mx - n_mn);
		job_b.smooth = new_smooth;
		job_b.sharp  = new_sharp;
		job_b.last   = 1'b1;

		if (second_q) begin
			push     = 1'b1;
			push_job = second_job_q;
		end else begin
			push     = accept && (held_q || s_tlast);
			push_job = held_q ? job_a : job_b;
		end
	end

	// Hold columns and pending samples
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q   <= held_q ? center_q : new_col;
			center_q <= new_col;
			smooth_q <= new_smooth;
			sharp_q  <= new_sharp;
			if (held_q && s_tlast) begin
				second_job_q <= job_b;
			end
		end
	end

	// Track held column and queued second job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (accept) begin
				held_q <= !s_tlast;
			end
			if (accept && held_q && s_tlast) begin
				second_q <= 1'b1;
			end else if (second_q && push_ready) begin
				second_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/euab_back.sv */
module euab_back import euab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	logic            adv;
	logic            v_s1, v_s2, v_s3, v_s4;
	logic [7:0]      span_s1;
	logic [3:0][7:0] smooth_s1, smooth_s2, smooth_s3, smooth_s4;
	logic [3:0][7:0] sharp_s1, sharp_s2, sharp_s3, sharp_s4;
	logic            last_s1, last_s2, last_s3, last_s4;
	logic [7:0]      w8_s2, w8_s3;
	logic [7:0]      ws_s3;
	logic [9:0]      wf_s4;

	logic [6:0]      ramp_x;
	logic [28:0]     ramp_prod;
	logic [7:0]      w8_next;
	logic [15:0]     sq_prod;
	logic [9:0]      k_fac;
	logic [17:0]     wf_prod;
	logic signed [8:0]  diff   [4];
	logic signed [19:0] scaled [4];
	logic signed [11:0] mixed  [4];
	logic [3:0][7:0]    blend;

	// Advance the whole pipe unless the output is stalled
	assign adv     = !m_tvalid || m_tready;
	assign job_pop = adv && job_valid;

	// Ramp weight from the range, then the smoothstep products
	always_comb begin
		ramp_x    = 7'(span_s1 - RampLow);
		ramp_prod = 29'(ramp_x) * 29'(RampRecip);
		if (span_s1 <= RampLow) begin
			w8_next = '0;
		end else if (span_s1 >= RampHigh) begin
			w8_next = FullWeight;
		end else begin
			w8_next = ramp_prod[RampShift +: 8];
		end
		sq_prod = 16'(w8_s2) * 16'(w8_s2);
		k_fac   = SmoothK - {1'b0, w8_s3, 1'b0};
		wf_prod = 18'(ws_s3) * 18'(k_fac);
	end

	// Blend each sample and clamp
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			diff[k]   = $signed({1'b0, sharp_s4[k]}) - $signed({1'b0, smooth_s4[k]});
			scaled[k] = 20'(diff[k]) * $signed({10'd0, wf_s4});
			mixed[k]  = $signed({4'd0, smooth_s4[k]}) + 12'(scaled[k] >>> 8);
			if (mixed[k] < 0) begin
				blend[k] = 8'd0;
			end else if (mixed[k] > 12'sd255) begin
				blend[k] = 8'd255;
			end else begin
				blend[k] = mixed[k][7:0];
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			span_s1   <= job.span;
			smooth_s1 <= job.smooth;
			sharp_s1  <= job.sharp;
			last_s1   <= job.last;

			w8_s2     <= w8_next;
			smooth_s2 <= smooth_s1;
			sharp_s2  <= sharp_s1;
			last_s2   <= last_s1;

			ws_s3     <= sq_prod[15:8];
			w8_s3     <= w8_s2;
			smooth_s3 <= smooth_s2;
			sharp_s3  <= sharp_s2;
			last_s3   <= last_s2;

			wf_s4     <= wf_prod[17:8];
			smooth_s4 <= smooth_s3;
			sharp_s4  <= sharp_s3;
			last_s4   <= last_s3;

			m_tdata   <= blend;
			m_tlast   <= last_s4;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1     <= job_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			m_tvalid <= v_s4;
		end
	end

endmodule

/* sv/edge_adaptive_upscale_blend_core.sv */
// Edge-adaptive 2x upscale blend. Each input transaction carries one source
// column (above, center, below) with the bicubic and rule-upscaled 2x2 blocks
// for that pixel; results are blended 2x2 blocks, one pixel behind the input.
// The first column of a row gives no result unless it has tlast, a middle
// column gives one, and a column with tlast gives the held column's result,
// if any, followed by its own. One transaction is taken per cycle while the
// job queue has room; a tlast transaction after a held column holds off the
// next one while the front issues its second job into the job queue. The
// back end is a five-stage pipe (range weight, smoothstep, blend). QUEUE_DEPTH
// sets how many jobs the front may run ahead of a stalled output.
module edge_adaptive_upscale_blend_core import euab_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// src_above, src_center, src_below, smooth_top_left, smooth_top_right,
	// smooth_bottom_left, smooth_bottom_right, sharp_top_left, sharp_top_right,
	// sharp_bottom_left, sharp_bottom_right
	input  logic [87:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// blend_top_left, blend_top_right, blend_bottom_left, blend_bottom_right
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	logic push;
	job_t push_job;
	logic push_ready;
	logic pop;
	logic pop_valid;
	job_t pop_job;

	euab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	euab_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	euab_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.job_pop   (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

/* sv/euab_checker.sv */
module euab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	logic       held_q;
	logic [7:0] owed_q;
	logic [7:0] pairs_q;
	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] add;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign add      = in_xfer ? (2'(held_q) + 2'(s_tlast)) : 2'd0;

	// Track results owed as seen from the ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owed_q  <= '0;
			pairs_q <= '0;
		end else begin
			if (in_xfer) begin
				held_q <= !s_tlast;
			end
			owed_q <= owed_q + 8'(add) - 8'(out_xfer);
			pairs_q <= pairs_q + 8'(in_xfer && held_q && s_tlast)
				- 8'(out_xfer && !m_tlast);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> owed_q != 8'd0)
		else $error("result without a transaction that causes it");

	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> pairs_q != 8'd0)
		else $error("non-last result outside a row-end pair");

	a_second_job: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && held_q && s_tlast |=> !s_tready)
		else $error("row end after held column not given a second cycle");

endmodule

bind edge_adaptive_upscale_blend_core euab_checker u_euab_checker (.*);

/* verif/edge_adaptive_upscale_blend_core_tb.sv */
`timescale 1ns / 1ps

module edge_adaptive_upscale_blend_core_tb;
	import euab_pkg::*;

	localparam int IdleLimit = 2000;
	localparam int DrainCycles = 20;

	// One source column as it travels on the slave side
	typedef struct packed {
		logic        row_end;
		logic [87:0] data;
	} column_item_t;

	// One blended 2x2 block as it travels on the master side
	typedef struct packed {
		logic        run_last;
		logic [31:0] block;
	} blend_block_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	column_item_t pending_columns[$];
	blend_block_t expected_blocks[$];
	column_item_t next_column;
	blend_block_t oldest_block;

	int send_idle_pct = 15;
	int recv_idle_pct = 46;
	int mismatches = 0;
	int idle_cycles = 0;

	string blend_names[4] = '{"blend_top_left", "blend_top_right",
		"blend_bottom_left", "blend_bottom_right"};

	// Predictor state: columns left of and at the held pixel, its 2x2 samples
	logic [2:0][7:0] left_col = '0;
	logic [2:0][7:0] mid_col = '0;
	logic [3:0][7:0] held_smooth = '0;
	logic [3:0][7:0] held_sharp = '0;
	logic            col_held = 1'b0;

	edge_adaptive_upscale_blend_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Weight the smooth and sharp blocks by the 3x3 min-max range
	function automatic logic [31:0] blend_block(logic [2:0][7:0] l, logic [2:0][7:0] c,
			logic [2:0][7:0] r, logic [3:0][7:0] sm, logic [3:0][7:0] sh);
		int unsigned lo, hi, span, w8, ws, wf;
		int t, v;
		logic [31:0] blk;
		lo = 255;
		hi = 0;
		for (int i = 0; i < 3; i++) begin
			if (l[i] < lo) lo = l[i];
			if (c[i] < lo) lo = c[i];
			if (r[i] < lo) lo = r[i];
			if (l[i] > hi) hi = l[i];
			if (c[i] > hi) hi = c[i];
			if (r[i] > hi) hi = r[i];
		end
		span = hi - lo;
		if (span <= RampLow)
			w8 = 0;
		else if (span >= RampHigh)
			w8 = FullWeight;
		else
			w8 = (span - RampLow) * FullWeight / (RampHigh - RampLow);
		// smoothstep: w^2 * (3 - 2w) in 8-bit fixed point
		ws = (w8 * w8) >> 8;
		wf = (ws * (SmoothK - 2 * w8)) >> 8;
		for (int k = 0; k < 4; k++) begin
			// bias keeps the product nonnegative so the shift floors
			t = (int'(sh[k]) - int'(sm[k])) * int'(wf) + 65536;
			v = int'(sm[k]) + (t >>> 8) - 256;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			blk[k*8 +: 8] = v[7:0];
		end
		return blk;
	endfunction

	// Advance the predictor by one accepted column and queue its results
	task automatic predict_column(logic [87:0] d, logic row_end);
		logic [2:0][7:0] nc;
		logic [3:0][7:0] sm, sh;
		nc = d[23:0];
		sm = d[55:24];
		sh = d[87:56];
		if (col_held) begin
			expected_blocks.push_back('{run_last: !row_end,
				block: blend_block(left_col, mid_col, nc, held_smooth, held_sharp)});
			left_col = mid_col;
		end else begin
			left_col = nc;
		end
		mid_col = nc;
		held_smooth = sm;
		held_sharp = sh;
		if (row_end) begin
			expected_blocks.push_back('{run_last: 1'b1,
				block: blend_block(left_col, mid_col, mid_col, held_smooth, held_sharp)});
			col_held = 1'b0;
		end else begin
			col_held = 1'b1;
		end
	endtask

	task automatic add_column(logic [7:0] above, logic [7:0] center, logic [7:0] below,
			logic [31:0] sm, logic [31:0] sh, logic row_end);
		pending_columns.push_back('{row_end: row_end, data: {sh, sm, below, center, above}});
	endtask

	function automatic logic [7:0] near_pixel(int base, int spread);
		int v;
		v = base + int'($urandom_range(spread));
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// Rows of random length; ranges biased around the weight ramp
	task automatic add_random_rows(int n_items);
		int made, len, mode, base, spread;
		logic [31:0] sm, sh;
		made = 0;
		while (made < n_items) begin
			len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 12);
			mode = $urandom_range(3);
			case (mode)
				0: spread = $urandom_range(30);
				1: spread = $urandom_range(60, 110);
				default: spread = 255;
			endcase
			base = (spread == 255) ? 0 : $urandom_range(255 - spread / 2);
			for (int i = 0; i < len; i++) begin
				sm = $urandom();
				sh = $urandom();
				if ($urandom_range(5) == 0) begin
					sm = {4{8'hff}};
					sh = '0;
				end
				add_column(near_pixel(base, spread), near_pixel(base, spread),
					near_pixel(base, spread), sm, sh, i == len - 1);
			end
			made += len;
		end
	endtask

	task automatic drain_pending();
		while (pending_columns.size() != 0)
			@(posedge clk);
	endtask

	// Drive source columns; predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_column(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_columns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_column = pending_columns.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_column.data;
					s_tlast <= next_column.row_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each blended transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_blocks.size() == 0) begin
					$error("unexpected result: data %h last %b", m_tdata, m_tlast);
					mismatches++;
				end else begin
					oldest_block = expected_blocks.pop_front();
					for (int k = 0; k < 4; k++) begin
						if (m_tdata[k*8 +: 8] !== oldest_block.block[k*8 +: 8]) begin
							$error("%s: expected %0d, actual %0d", blend_names[k],
								oldest_block.block[k*8 +: 8], m_tdata[k*8 +: 8]);
							mismatches++;
						end
					end
					if (m_tlast !== oldest_block.run_last) begin
						$error("run_last: expected %b, actual %b",
							oldest_block.run_last, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stop a hung run: count cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// single-column rows at the extremes
		add_column(8'd0, 8'd0, 8'd0, '0, '0, 1'b1);
		add_column(8'd255, 8'd255, 8'd255, '0, {4{8'hff}}, 1'b1);
		// two-column row, range exactly at the low ramp end
		add_column(8'd0, 8'd0, 8'd0, 32'h00ff_80ff, 32'hff00_7f00, 1'b0);
		add_column(8'd24, 8'd24, 8'd24, 32'h1234_5678, 32'hfedc_ba98, 1'b1);
		// three-column row, range just above the ramp start
		add_column(8'd0, 8'd0, 8'd0, 32'h0000_0000, 32'hffff_ffff, 1'b0);
		add_column(8'd0, 8'd25, 8'd0, 32'h8080_8080, 32'h7f81_00ff, 1'b0);
		add_column(8'd0, 8'd0, 8'd0, 32'hffff_ffff, 32'h0000_0000, 1'b1);
		// three-column row, range just below the ramp top
		add_column(8'd100, 8'd100, 8'd5, 32'h0000_00ff, 32'hff00_ff00, 1'b0);
		add_column(8'd100, 8'd100, 8'd100, 32'h55aa_55aa, 32'haa55_aa55, 1'b0);
		add_column(8'd100, 8'd100, 8'd100, 32'h0102_0304, 32'hfcfd_feff, 1'b1);
		// full-range edges: ramp top and full swing, sharp below then above smooth
		add_column(8'd0, 8'd96, 8'd0, {4{8'hff}}, '0, 1'b0);
		add_column(8'd255, 8'd0, 8'd255, {4{8'hff}}, '0, 1'b0);
		add_column(8'd0, 8'd255, 8'd0, '0, {4{8'hff}}, 1'b1);
		// four-column row mixing ramp regions
		add_column(8'd40, 8'd80, 8'd60, $urandom(), $urandom(), 1'b0);
		add_column(8'd50, 8'd50, 8'd50, $urandom(), $urandom(), 1'b0);
		add_column(8'd200, 8'd10, 8'd130, $urandom(), $urandom(), 1'b0);
		add_column(8'd128, 8'd127, 8'd129, $urandom(), $urandom(), 1'b1);

		add_random_rows(250);
		drain_pending();
		send_idle_pct = 46;
		recv_idle_pct = 15;
		add_random_rows(250);
		drain_pending();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_rows(250);

		// let the last column go, then drain the blend pipe
		while (pending_columns.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0 && expected_blocks.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
